// ----- rtl/core/tad_pkg.sv -----
package tad_pkg;

  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 9;
  localparam int ID_W    = 24;
  localparam int SIZE_W  = 36;
  localparam int POS_W   = 37;
  localparam int TYPE_W  = 3;
  localparam int KIND_W  = 2;

  localparam logic [OFF_W-1:0] OFF_FIRST     = 9'd0;
  localparam logic [OFF_W-1:0] OFF_LAST      = 9'd511;
  localparam logic [OFF_W-1:0] OFF_MODE      = 9'd100;
  localparam logic [OFF_W-1:0] OFF_UID       = 9'd108;
  localparam logic [OFF_W-1:0] OFF_GID       = 9'd116;
  localparam logic [OFF_W-1:0] OFF_SIZE      = 9'd124;
  localparam logic [OFF_W-1:0] OFF_MTIME     = 9'd136;
  localparam logic [OFF_W-1:0] OFF_MTIME_END = 9'd148;
  localparam logic [OFF_W-1:0] OFF_TYPE      = 9'd156;

  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;
  localparam logic [TYPE_W-1:0] DIR_TYPE = 3'd5;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_PADDING = 2'd2,
    PH_ENDED   = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // control from the sequencer to the header field decoder
  typedef struct packed {
    logic              clear;
    logic              step;
    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] data;
  } hdr_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0]   mode;
    logic [ID_W-1:0]   uid;
    logic [ID_W-1:0]   gid;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] mtime;
    logic [TYPE_W-1:0] ftype;
  } hdr_fields_t;

  // '0' .. '7'
  function automatic logic is_octal_digit(input logic [BYTE_W-1:0] b);
    return b[7:3] == 5'b00110;
  endfunction

endpackage

// ----- rtl/core/tad_in_if.sv -----
interface tad_in_if;
  logic                       valid;
  logic                       ready;
  logic [tad_pkg::BYTE_W-1:0] archive_byte;
  logic                       archive_end;

  modport source (output valid, output archive_byte, output archive_end, input ready);
  modport sink (input valid, input archive_byte, input archive_end, output ready);
endinterface

// ----- rtl/core/tad_out_if.sv -----
interface tad_out_if;
  logic                       valid;
  logic                       ready;
  logic [tad_pkg::KIND_W-1:0] kind;
  logic                       is_directory;
  logic [tad_pkg::ID_W-1:0]   permissions;
  logic [tad_pkg::ID_W-1:0]   owner_id;
  logic [tad_pkg::ID_W-1:0]   group_id;
  logic [tad_pkg::SIZE_W-1:0] file_size;
  logic [tad_pkg::SIZE_W-1:0] modify_time;
  logic [tad_pkg::BYTE_W-1:0] payload_byte;
  logic                       payload_last;

  modport source (output valid, output kind, output is_directory, output permissions,
                  output owner_id, output group_id, output file_size, output modify_time,
                  output payload_byte, output payload_last, input ready);
  modport sink (input valid, input kind, input is_directory, input permissions,
                input owner_id, input group_id, input file_size, input modify_time,
                input payload_byte, input payload_last, output ready);
endinterface

// ----- rtl/core/tad_header_decoder.sv -----
module tad_header_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  tad_pkg::hdr_ctl_t    ctl,
  output tad_pkg::hdr_fields_t fields
);
  import tad_pkg::*;

  hdr_fields_t acc, acc_next;
  logic        field_stopped, field_stopped_next;

  logic in_mode, in_uid, in_gid, in_size, in_mtime, in_type, in_field;
  logic at_start, stopped_eff, is_nul, take, digit;

  always_comb begin
    in_mode  = ctl.off >= OFF_MODE  && ctl.off < OFF_UID;
    in_uid   = ctl.off >= OFF_UID   && ctl.off < OFF_GID;
    in_gid   = ctl.off >= OFF_GID   && ctl.off < OFF_SIZE;
    in_size  = ctl.off >= OFF_SIZE  && ctl.off < OFF_MTIME;
    in_mtime = ctl.off >= OFF_MTIME && ctl.off < OFF_MTIME_END;
    in_type  = ctl.off == OFF_TYPE;
    in_field = in_mode | in_uid | in_gid | in_size | in_mtime | in_type;
    at_start = ctl.off == OFF_MODE || ctl.off == OFF_UID || ctl.off == OFF_GID ||
               ctl.off == OFF_SIZE || ctl.off == OFF_MTIME || ctl.off == OFF_TYPE;
    stopped_eff = field_stopped & ~at_start;
    is_nul      = ctl.data == NUL_BYTE;
    digit       = is_octal_digit(ctl.data);
    take        = ctl.step & in_field & ~stopped_eff & ~is_nul;

    acc_next           = acc;
    field_stopped_next = field_stopped;
    if (ctl.clear) begin
      acc_next           = '0;
      field_stopped_next = 1'b0;
    end else begin
      if (ctl.step && in_field) field_stopped_next = stopped_eff | is_nul;
      if (take) begin
        // a non-digit restarts the run, so only trailing digits count
        if (in_mode)  acc_next.mode  = digit ? {acc.mode[ID_W-4:0], ctl.data[2:0]} : '0;
        if (in_uid)   acc_next.uid   = digit ? {acc.uid[ID_W-4:0], ctl.data[2:0]} : '0;
        if (in_gid)   acc_next.gid   = digit ? {acc.gid[ID_W-4:0], ctl.data[2:0]} : '0;
        if (in_size)  acc_next.size  = digit ? {acc.size[SIZE_W-4:0], ctl.data[2:0]} : '0;
        if (in_mtime) acc_next.mtime = digit ? {acc.mtime[SIZE_W-4:0], ctl.data[2:0]} : '0;
        if (in_type)  acc_next.ftype = digit ? ctl.data[2:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      field_stopped <= 1'b0;
    end else begin
      acc           <= acc_next;
      field_stopped <= field_stopped_next;
    end
  end

  assign fields = acc;

endmodule

// ----- rtl/core/tar_archive_deframer.sv -----
// Tar archive deframer.
// archive: one raw archive byte per item, archive_end set on the final byte.
// record:  entry records (kind 0) after each 512-byte header, payload bytes
//          (kind 1, payload_last on the entry's last content byte) and one
//          end-of-archive record (kind 2) for a header that opens with NUL.
//          Padding bytes and bytes after the end record give no item.
// Throughput: one archive byte per cycle, sustained while record.ready is
// high or the output register is free. The byte goes into an input
// register; from there the field decoder and the phase/position counters
// act on it and any record lands in the output register, where it stays
// valid until taken. The critical path is the 37-bit position increment
// and compare against size and padded size.
// When record.ready is low the output register holds its record; the input
// register still takes one more byte, then archive.ready drops until the
// record is taken. Bytes that make no record pass even while stalled only
// if the output register is free.
// Reset (rst, synchronous) empties both registers and returns to the header
// phase at offset 0; an item with archive_end returns to the header phase at offset 0 after its byte.
module tar_archive_deframer (
  input logic      clk,
  input logic      rst,
  tad_in_if.sink   archive,
  tad_out_if.source record
);
  import tad_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_end;
  logic              fire;

  phase_t            phase, phase_next;
  logic [OFF_W-1:0]  block_offset, block_offset_next;
  logic [POS_W-1:0]  data_position, data_position_next;
  logic [POS_W-1:0]  padded_length, padded_length_next;

  hdr_ctl_t    hctl;
  hdr_fields_t hf;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind, out_kind_next;
  logic              out_dir, out_dir_next;
  logic [ID_W-1:0]   out_mode, out_mode_next, out_uid, out_uid_next, out_gid, out_gid_next;
  logic [SIZE_W-1:0] out_size, out_size_next, out_mtime, out_mtime_next;
  logic [BYTE_W-1:0] out_byte, out_byte_next;
  logic              out_last, out_last_next;
  logic              emit;

  logic [POS_W-1:0]  pos_inc, size_ext, pad_sum;

  assign fire          = s1_valid && (!out_valid || record.ready);
  assign archive.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (archive.ready) begin
      s1_valid <= archive.valid;
    end
    if (archive.ready && archive.valid) begin
      s1_byte <= archive.archive_byte;
      s1_end  <= archive.archive_end;
    end
  end

  always_comb begin
    hctl.clear = fire && (s1_end || (phase == PH_HEADER && block_offset == OFF_FIRST));
    hctl.step  = fire && phase == PH_HEADER && block_offset != OFF_FIRST;
    hctl.off   = block_offset;
    hctl.data  = s1_byte;
  end

  tad_header_decoder u_hdr (
    .clk    (clk),
    .rst    (rst),
    .ctl    (hctl),
    .fields (hf)
  );

  always_comb begin
    pos_inc  = data_position + POS_W'(1);
    size_ext = {1'b0, hf.size};
    pad_sum  = size_ext + POS_W'(OFF_LAST);

    phase_next         = phase;
    block_offset_next  = block_offset;
    data_position_next = data_position;
    padded_length_next = padded_length;
    emit           = 1'b0;
    out_kind_next  = KIND_ENTRY;
    out_dir_next   = 1'b0;
    out_mode_next  = '0;
    out_uid_next   = '0;
    out_gid_next   = '0;
    out_size_next  = '0;
    out_mtime_next = '0;
    out_byte_next  = '0;
    out_last_next  = 1'b0;

    case (phase)
      PH_HEADER: begin
        if (block_offset == OFF_FIRST && s1_byte == NUL_BYTE) begin
          emit              = 1'b1;
          out_kind_next     = KIND_END;
          phase_next        = PH_ENDED;
          block_offset_next = '0;
        end else if (block_offset == OFF_LAST) begin
          emit               = 1'b1;
          out_kind_next      = KIND_ENTRY;
          out_dir_next       = hf.ftype == DIR_TYPE;
          out_mode_next      = hf.mode;
          out_uid_next       = hf.uid;
          out_gid_next       = hf.gid;
          out_size_next      = hf.size;
          out_mtime_next     = hf.mtime;
          block_offset_next  = '0;
          data_position_next = '0;
          padded_length_next = {pad_sum[POS_W-1:OFF_W], {OFF_W{1'b0}}};
          phase_next         = (hf.size == '0) ? PH_HEADER : PH_PAYLOAD;
        end else begin
          block_offset_next = block_offset + OFF_W'(1);
        end
      end
      PH_PAYLOAD: begin
        data_position_next = pos_inc;
        emit          = 1'b1;
        out_kind_next = KIND_PAYLOAD;
        out_byte_next = s1_byte;
        if (pos_inc >= size_ext) begin
          out_last_next = 1'b1;
          phase_next    = (pos_inc >= padded_length) ? PH_HEADER : PH_PADDING;
        end
      end
      PH_PADDING: begin
        data_position_next = pos_inc;
        if (pos_inc >= padded_length) phase_next = PH_HEADER;
      end
      default: begin
        // ended: bytes are dropped until archive_end
      end
    endcase

    if (s1_end) begin
      phase_next         = PH_HEADER;
      block_offset_next  = '0;
      data_position_next = '0;
      padded_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      block_offset  <= '0;
      data_position <= '0;
      padded_length <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        phase         <= phase_next;
        block_offset  <= block_offset_next;
        data_position <= data_position_next;
        padded_length <= padded_length_next;
        out_valid     <= emit;
      end else if (record.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire && emit) begin
      out_kind  <= out_kind_next;
      out_dir   <= out_dir_next;
      out_mode  <= out_mode_next;
      out_uid   <= out_uid_next;
      out_gid   <= out_gid_next;
      out_size  <= out_size_next;
      out_mtime <= out_mtime_next;
      out_byte  <= out_byte_next;
      out_last  <= out_last_next;
    end
  end

  assign record.valid        = out_valid;
  assign record.kind         = out_kind;
  assign record.is_directory = out_dir;
  assign record.permissions  = out_mode;
  assign record.owner_id     = out_uid;
  assign record.group_id     = out_gid;
  assign record.file_size    = out_size;
  assign record.modify_time  = out_mtime;
  assign record.payload_byte = out_byte;
  assign record.payload_last = out_last;

  // payload phase always has content left to pass
  a_payload_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> data_position < {1'b0, hf.size})
    else $error("payload phase with no content left");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    fire && s1_end |=> phase == PH_HEADER && block_offset == '0 && data_position == '0)
    else $error("archive_end did not restart the parser");

  a_ended_offset: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ENDED |-> block_offset == '0)
    else $error("block offset moved after end of archive");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_kind == KIND_PAYLOAD)
    else $error("last flag on a non-payload record");

endmodule
